>>> src/pureg_pkg.sv
`timescale 1ns / 1ps
package pureg_pkg;

	localparam logic [2:0] OP_WRITE    = 3'd0;
	localparam logic [2:0] OP_READ     = 3'd1;
	localparam logic [2:0] OP_VBL_SET  = 3'd2;
	localparam logic [2:0] OP_VBL_CLR  = 3'd3;
	localparam logic [2:0] OP_DOT_TICK = 3'd4;

	localparam logic [2:0] REG_CTRL    = 3'd0;
	localparam logic [2:0] REG_MASK    = 3'd1;
	localparam logic [2:0] REG_STATUS  = 3'd2;
	localparam logic [2:0] REG_OAMADDR = 3'd3;
	localparam logic [2:0] REG_OAMDATA = 3'd4;
	localparam logic [2:0] REG_SCROLL  = 3'd5;
	localparam logic [2:0] REG_ADDR    = 3'd6;
	localparam logic [2:0] REG_DATA    = 3'd7;

	localparam logic [1:0] MIR_HORIZ = 2'd0;
	localparam logic [1:0] MIR_VERT  = 2'd1;

	localparam logic [13:0] PAL_BASE = 14'h3F00;
	localparam logic [13:0] NT_BASE  = 14'h2000;

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_EXEC  = 3'b100
	} st_t;

	typedef logic [7:0] pal_t [32];

	localparam pal_t PAL_INIT = '{
		8'h09, 8'h01, 8'h00, 8'h01, 8'h00, 8'h02, 8'h02, 8'h0D,
		8'h08, 8'h10, 8'h08, 8'h24, 8'h00, 8'h00, 8'h04, 8'h2C,
		8'h09, 8'h01, 8'h34, 8'h03, 8'h00, 8'h04, 8'h00, 8'h14,
		8'h08, 8'h3A, 8'h00, 8'h02, 8'h00, 8'h20, 8'h2C, 8'h08
	};

endpackage

>>> src/pureg_if.sv
`timescale 1ns / 1ps
interface pureg_req_if;
	logic       valid;
	logic       ready;
	logic [2:0] operation;
	logic [2:0] reg_index;
	logic [7:0] write_data;
	logic [7:0] pattern_byte;
	modport source (output valid, operation, reg_index, write_data, pattern_byte, input ready);
	modport sink   (input valid, operation, reg_index, write_data, pattern_byte, output ready);
endinterface

interface pureg_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic       nmi_pulse;
	modport source (output valid, read_data, nmi_pulse, input ready);
	modport sink   (input valid, read_data, nmi_pulse, output ready);
endinterface

interface pureg_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] data;
	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

>>> src/picture_unit_register_port_core.sv
`timescale 1ns / 1ps
// picture unit cpu register port
// req channel: one beat per bus access (write, read), vblank event or dot tick
// rsp channel: exactly one beat per req beat, in order: read_data and nmi_pulse
// cfg channel: writes the mirroring mode, always ready; write only while idle
// an accepted req beat moves the core to exec; rsp.valid is registered as exec ends
// no req beat is taken while an item is in exec, due to the read-modify-write of the
//   synchronous nametable/object memories (read on accept, write back next cycle)
// the rsp register holds a result while the receiver stalls; a new req beat is
//   taken only once that register is free or being drained in the same cycle
// reset: state and control registers go to power-up values, palette to its table,
//   then a clearing pass over all NAMETABLE_BYTES addresses fills nametable and
//   object memory with 0xFF; req.ready stays low during that pass
// nmi: rising edge of (vblank and control bit 7) loads a countdown of NMI_DELAY_TICKS;
//   dot ticks count it down; nmi pulses at zero if vblank and ctrl bit 7 still hold
module picture_unit_register_port_core
	import pureg_pkg::*;
#(
	parameter int NAMETABLE_BYTES = 4096,
	parameter int NMI_DELAY_TICKS = 15
) (
	input  logic        clk,
	input  logic        arst_n,
	pureg_req_if.sink   req,
	pureg_rsp_if.source rsp,
	pureg_cfg_if.sink   cfg
);

	localparam int NT_AW = $clog2(NAMETABLE_BYTES);
	localparam logic [13:0] NB1 = 14'(NAMETABLE_BYTES);
	localparam logic [13:0] NB2 = 14'(2 * NAMETABLE_BYTES);
	localparam logic [NT_AW-1:0] CLR_LAST = NT_AW'(NAMETABLE_BYTES - 1);
	localparam logic [3:0] NMI_LOAD = 4'(NMI_DELAY_TICKS);

	// memories
	logic [7:0] nt_mem  [NAMETABLE_BYTES];
	logic [7:0] obj_mem [256];
	logic [7:0] pal_q   [32];

	st_t              st_q;
	logic [NT_AW-1:0] clr_q;
	logic [1:0]       mir_q;

	// architectural registers
	logic [7:0]  ctrl_q, mask_q, oam_q, lw_q, buf_q;
	logic        vbl_q, w_q, prev_q;
	logic [14:0] v_q, t_q;
	logic [2:0]  fx_q;
	logic [3:0]  cnt_q;

	// captured item
	logic [2:0] op_s1, reg_s1;
	logic [7:0] wd_s1, pat_s1;
	logic [7:0] nt_rd_s1, obj_rd_s1;

	// result register
	logic       ov_q, pulse_q;
	logic [7:0] rd_q;

	logic accept;
	assign req.ready = (st_q == ST_IDLE) && (!ov_q || rsp.ready);
	assign accept    = req.valid && req.ready;
	assign cfg.ready = 1'b1;
	assign rsp.valid     = ov_q;
	assign rsp.read_data = rd_q;
	assign rsp.nmi_pulse = pulse_q;

	// data port address decode, valid both on accept and in the exec cycle
	logic [13:0]      a, sel, x, x1;
	logic [NT_AW-1:0] nt_idx;
	logic [4:0]       pal_idx;
	always_comb begin
		a   = v_q[13:0];
		// palette reads also fetch the nametable byte 0x1000 below
		sel = (a >= PAL_BASE) ? a - 14'h1000 : a;
		x   = {1'b0, sel[12:0]};
		x1  = (x >= NB2) ? x - NB2 : x;
		x1  = (x1 >= NB1) ? x1 - NB1 : x1;
		priority if (mir_q == MIR_VERT) begin
			nt_idx = NT_AW'(sel[10:0]);
		end else if (mir_q == MIR_HORIZ) begin
			nt_idx = NT_AW'({sel[11], sel[9:0]});
		end else begin
			nt_idx = x1[NT_AW-1:0];
		end
		pal_idx = a[4:0];
		if (pal_idx[4] && pal_idx[1:0] == 2'b00) begin
			pal_idx[4] = 1'b0;
		end
	end

	// exec cycle: next state of everything
	logic [7:0]  ctrl_d, mask_d, oam_d, lw_d, buf_d, rd_d, data_d;
	logic        vbl_d, w_d, prev_d, pulse_d, nmi_eval, adv;
	logic [14:0] v_d, t_d;
	logic [2:0]  fx_d;
	logic [3:0]  cnt_d;
	logic        nt_we, obj_we, pal_we;
	always_comb begin
		ctrl_d = ctrl_q; mask_d = mask_q; oam_d = oam_q; lw_d = lw_q; buf_d = buf_q;
		vbl_d = vbl_q; w_d = w_q; prev_d = prev_q; v_d = v_q; t_d = t_q;
		fx_d = fx_q; cnt_d = cnt_q;
		rd_d = 8'h00; pulse_d = 1'b0; nmi_eval = 1'b0; adv = 1'b0;
		nt_we = 1'b0; obj_we = 1'b0; pal_we = 1'b0;
		if (a < NT_BASE) begin
			data_d = pat_s1;
		end else if (a < PAL_BASE) begin
			data_d = nt_rd_s1;
		end else begin
			data_d = pal_q[pal_idx];
		end
		if (op_s1 == OP_WRITE) begin
			lw_d = wd_s1;
			unique case (reg_s1)
				REG_CTRL: begin
					ctrl_d = wd_s1;
					t_d[11:10] = wd_s1[1:0];
					nmi_eval = 1'b1;
				end
				REG_MASK: mask_d = wd_s1;
				REG_OAMADDR: oam_d = wd_s1;
				REG_OAMDATA: begin
					obj_we = 1'b1;
					oam_d = oam_q + 8'd1;
				end
				REG_SCROLL: begin
					if (w_q) begin
						t_d[4:0] = wd_s1[7:3];
						fx_d = wd_s1[2:0];
					end else begin
						t_d[14:12] = wd_s1[2:0];
						t_d[9:5] = wd_s1[7:3];
					end
					w_d = !w_q;
				end
				REG_ADDR: begin
					if (w_q) begin
						t_d[14:8] = {1'b0, wd_s1[5:0]};
					end else begin
						t_d[7:0] = wd_s1;
						v_d = t_d;
					end
					w_d = !w_q;
				end
				REG_DATA: begin
					// pattern range writes are dropped
					if (a >= NT_BASE) begin
						if (a < PAL_BASE) nt_we = 1'b1;
						else pal_we = 1'b1;
					end
					adv = 1'b1;
				end
				default: ;
			endcase
		end else if (op_s1 == OP_READ) begin
			if (reg_s1 == REG_STATUS) begin
				rd_d = {vbl_q, 2'b00, lw_q[4:0]};
				vbl_d = 1'b0;
				nmi_eval = 1'b1;
				w_d = 1'b1;
			end else if (reg_s1 == REG_OAMDATA) begin
				rd_d = obj_rd_s1;
			end else if (reg_s1 == REG_DATA) begin
				if (a < PAL_BASE) begin
					rd_d = buf_q;
					buf_d = data_d;
				end else begin
					rd_d = data_d;
					buf_d = nt_rd_s1;
				end
				adv = 1'b1;
			end
		end else if (op_s1 == OP_VBL_SET) begin
			vbl_d = 1'b1;
			nmi_eval = 1'b1;
		end else if (op_s1 == OP_VBL_CLR) begin
			vbl_d = 1'b0;
			nmi_eval = 1'b1;
		end else if (op_s1 == OP_DOT_TICK) begin
			if (cnt_q != 4'd0) begin
				cnt_d = cnt_q - 4'd1;
				pulse_d = (cnt_d == 4'd0) && ctrl_q[7] && vbl_q;
			end
		end
		if (adv) begin
			v_d = v_q + (ctrl_q[2] ? 15'd32 : 15'd1);
		end
		if (nmi_eval) begin
			if (vbl_d && ctrl_d[7] && !prev_q) cnt_d = NMI_LOAD;
			prev_d = vbl_d && ctrl_d[7];
		end
	end

	// nametable and object memory: clearing pass, then read on accept, write in exec
	always_ff @(posedge clk) begin
		if (st_q == ST_CLEAR) begin
			nt_mem[clr_q] <= 8'hFF;
			if (clr_q[NT_AW-1:8] == '0) obj_mem[clr_q[7:0]] <= 8'hFF;
		end else if (st_q == ST_EXEC) begin
			if (nt_we) nt_mem[nt_idx] <= wd_s1;
			if (obj_we) obj_mem[oam_q] <= wd_s1;
		end
		nt_rd_s1  <= nt_mem[nt_idx];
		obj_rd_s1 <= obj_mem[oam_q];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1  <= req.operation;
			reg_s1 <= req.reg_index;
			wd_s1  <= req.write_data;
			pat_s1 <= req.pattern_byte;
		end
		if (st_q == ST_EXEC) begin
			rd_q    <= rd_d;
			pulse_q <= pulse_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLEAR; clr_q <= '0; mir_q <= MIR_HORIZ; ov_q <= 1'b0;
			ctrl_q <= '0; mask_q <= '0; oam_q <= '0; lw_q <= '0; buf_q <= '0;
			vbl_q <= 1'b0; w_q <= 1'b1; prev_q <= 1'b0; v_q <= '0; t_q <= '0;
			fx_q <= '0; cnt_q <= '0;
			pal_q <= PAL_INIT;
		end else begin
			if (cfg.valid) mir_q <= cfg.data;
			if (st_q == ST_EXEC) ov_q <= 1'b1;
			else if (rsp.ready) ov_q <= 1'b0;
			unique case (st_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLR_LAST) st_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept) st_q <= ST_EXEC;
				end
				ST_EXEC: begin
					st_q <= ST_IDLE;
					ctrl_q <= ctrl_d; mask_q <= mask_d; oam_q <= oam_d; lw_q <= lw_d;
					buf_q <= buf_d; vbl_q <= vbl_d; w_q <= w_d; prev_q <= prev_d;
					v_q <= v_d; t_q <= t_d; fx_q <= fx_d; cnt_q <= cnt_d;
					if (pal_we) pal_q[pal_idx] <= wd_s1;
				end
				default: st_q <= ST_CLEAR;
			endcase
		end
	end

endmodule
